[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define SFCV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SFCV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SFCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sfcv_pkg.sv]
// Types and constants of the sysex frame checker.
// No dependencies; imported by every module of the block.
package sfcv_pkg;

    localparam int CNT_W = 13;

    localparam logic [CNT_W-1:0] CNT_MAX       = 13'd8191;
    localparam logic [CNT_W-1:0] SINGLE_LEN    = 13'd163;
    localparam logic [CNT_W-1:0] BANK_LEN      = 13'd4104;
    localparam logic [CNT_W-1:0] PAYLOAD_FIRST = 13'd6;

    localparam logic [7:0] MARK_START = 8'hF0;
    localparam logic [7:0] MARK_END   = 8'hF7;
    localparam logic [7:0] MAKER_ID   = 8'h43;

    localparam logic [7:0] SINGLE_H3 = 8'h00;
    localparam logic [7:0] SINGLE_H4 = 8'h01;
    localparam logic [7:0] SINGLE_H5 = 8'h1B;
    localparam logic [7:0] BANK_H3   = 8'h09;
    localparam logic [7:0] BANK_H4   = 8'h20;
    localparam logic [7:0] BANK_H5   = 8'h00;

    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_MARKER   = 3'd2,
        ST_HEADER   = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    // One classified byte, as handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       bank;
        logic       start_bad;
        logic       hdr_bad;
        logic       payload;
        logic       cksum_pos;
        logic       len_ok;
        logic       end_bad;
        logic       last;
    } byte_class_t;

endpackage

[hw/rtl/sfcv_front.sv]
// Front end: mode register, byte counter and per-byte classification.
// Depends on sfcv_pkg.
module sfcv_front
    import sfcv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_mode_we,
    input  logic        frame_mode_wdata,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        end_of_frame,
    output byte_class_t cls
);

    logic             mode_reg;
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [CNT_W-1:0] frame_len;
    logic [7:0]       h3;
    logic [7:0]       h4;
    logic [7:0]       h5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            byte_count_reg <= '0;
        end
        else
        begin
            if (frame_mode_we)
            begin
                mode_reg <= frame_mode_wdata;
            end
            if (accept)
            begin
                byte_count_reg <= byte_count_next;
            end
        end
    end

    always_comb
    begin
        frame_len = mode_reg ? BANK_LEN  : SINGLE_LEN;
        h3        = mode_reg ? BANK_H3   : SINGLE_H3;
        h4        = mode_reg ? BANK_H4   : SINGLE_H4;
        h5        = mode_reg ? BANK_H5   : SINGLE_H5;

        if (end_of_frame)
        begin
            byte_count_next = '0;
        end
        else if (byte_count_reg != CNT_MAX)
        begin
            byte_count_next = byte_count_reg + 1'b1;
        end
        else
        begin
            byte_count_next = byte_count_reg;
        end

        cls.data      = data_byte;
        cls.bank      = mode_reg;
        cls.start_bad = (byte_count_reg == 13'd0) && (data_byte != MARK_START);
        cls.hdr_bad   = ((byte_count_reg == 13'd1) && (data_byte != MAKER_ID))
                     || ((byte_count_reg == 13'd3) && (data_byte != h3))
                     || ((byte_count_reg == 13'd4) && (data_byte != h4))
                     || ((byte_count_reg == 13'd5) && (data_byte != h5));
        cls.payload   = (byte_count_reg >= PAYLOAD_FIRST)
                     && (byte_count_reg <= frame_len - 13'd3);
        cls.cksum_pos = byte_count_reg == frame_len - 13'd2;
        cls.len_ok    = byte_count_reg == frame_len - 13'd1;
        cls.end_bad   = data_byte != MARK_END;
        cls.last      = end_of_frame;
    end

endmodule

[hw/rtl/sfcv_queue.sv]
// Short FIFO of classified bytes between front and back.
// Depends on sfcv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfcv_queue
    import sfcv_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_class_t push_data,
    input  logic        pop,
    output byte_class_t head,
    output logic        empty,
    output logic        full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    byte_class_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    assign empty = fill_reg == '0;
    assign full  = fill_reg == FILL_W'(DEPTH);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    `SFCV_ASSERT_ALWAYS(a_no_overflow, !(push && full), "queue push while full")
    `SFCV_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "queue pop while empty")
    `SFCV_ASSERT_SAME(a_ptr_match, empty || full, wr_ptr_reg == rd_ptr_reg, "pointer mismatch")

endmodule

[hw/rtl/sfcv_back.sv]
// Back end: payload sum, checksum capture, error flags and verdict register.
// Depends on sfcv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfcv_back
    import sfcv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  byte_class_t head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [6:0]  computed_sum,
    output logic [7:0]  received_sum
);

    logic [6:0] running_sum_reg;
    logic [6:0] running_sum_next;
    logic [7:0] captured_sum_reg;
    logic [7:0] captured_sum_next;
    logic       start_bad_reg;
    logic       start_bad_next;
    logic       hdr_bad_reg;
    logic       hdr_bad_next;
    logic       out_valid_reg;
    status_t    status_reg;
    status_t    status_next;
    logic [6:0] computed_sum_reg;
    logic [6:0] calc_sum;
    logic [7:0] received_sum_reg;

    // Non-final bytes never need the output slot.
    assign pop = !empty && (!head.last || !out_valid_reg || !out_stall);

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign computed_sum = computed_sum_reg;
    assign received_sum = received_sum_reg;

    always_comb
    begin
        running_sum_next  = head.payload ? running_sum_reg + head.data[6:0] : running_sum_reg;
        captured_sum_next = head.cksum_pos ? head.data : captured_sum_reg;
        start_bad_next    = start_bad_reg | head.start_bad;
        hdr_bad_next      = hdr_bad_reg | head.hdr_bad;
        calc_sum          = 7'd0 - running_sum_next;

        if (!head.len_ok)
        begin
            status_next = ST_LENGTH;
        end
        else if (!head.bank)
        begin
            priority if (start_bad_next || head.end_bad)
                status_next = ST_MARKER;
            else if (hdr_bad_next)
                status_next = ST_HEADER;
            else if ({1'b0, calc_sum} != captured_sum_next)
                status_next = ST_CHECKSUM;
            else
                status_next = ST_VALID;
        end
        else
        begin
            // bank frames report a bad start marker as a header fault
            priority if (start_bad_next || hdr_bad_next)
                status_next = ST_HEADER;
            else if (head.end_bad)
                status_next = ST_MARKER;
            else if ({1'b0, calc_sum} != captured_sum_next)
                status_next = ST_CHECKSUM;
            else
                status_next = ST_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg  <= '0;
            captured_sum_reg <= '0;
            start_bad_reg    <= 1'b0;
            hdr_bad_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop && head.last)
            begin
                running_sum_reg  <= '0;
                captured_sum_reg <= '0;
                start_bad_reg    <= 1'b0;
                hdr_bad_reg      <= 1'b0;
                out_valid_reg    <= 1'b1;
            end
            else
            begin
                if (pop)
                begin
                    running_sum_reg  <= running_sum_next;
                    captured_sum_reg <= captured_sum_next;
                    start_bad_reg    <= start_bad_next;
                    hdr_bad_reg      <= hdr_bad_next;
                end
                if (!out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            status_reg       <= status_next;
            computed_sum_reg <= calc_sum;
            received_sum_reg <= captured_sum_next;
        end
    end

    `SFCV_ASSERT_NEXT(a_frame_cleared, pop && head.last,
        running_sum_reg == '0 && captured_sum_reg == '0 && !start_bad_reg && !hdr_bad_reg,
        "frame state not cleared after verdict")
    `SFCV_ASSERT_SAME(a_verdict_source, $rose(out_valid_reg), $past(pop && head.last),
        "result raised without a final byte")
    `SFCV_ASSERT_SAME(a_valid_sums, out_valid_reg && status_reg == ST_VALID,
        {1'b0, computed_sum_reg} == received_sum_reg, "valid verdict with unequal sums")

endmodule

[hw/rtl/sysex_frame_checksum_validator_core.sv]
// Top level of the sysex frame checker: front, queue and back end.
// Depends on sfcv_pkg, sfcv_front, sfcv_queue and sfcv_back.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, data_byte, end_of_frame | into block
//  out     | out_valid, out_stall, status, computed_sum, | out of block
//          | received_sum                              |
//  config  | frame_mode_we, frame_mode_wdata           | into block
//
// One byte per cycle sustained while in_stall is low; a byte leaves the front in
// the cycle it is taken and is folded into the frame state when it leaves the
// queue. The verdict appears in the cycle after the final byte is popped.
// Reset clears the mode to single-voice and all frame state; no clearing pass.
// in_stall rises only while the queue is full, which happens when out_stall
// holds a verdict and bytes pile up behind a further final byte at the head.
module sysex_frame_checksum_validator_core
    import sfcv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_mode_we,
    input  logic       frame_mode_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_frame,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [6:0] computed_sum,
    output logic [7:0] received_sum
);

    byte_class_t cls;
    byte_class_t head;
    logic        accept;
    logic        pop;
    logic        empty;
    logic        full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    sfcv_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .frame_mode_we    (frame_mode_we),
        .frame_mode_wdata (frame_mode_wdata),
        .accept           (accept),
        .data_byte        (data_byte),
        .end_of_frame     (end_of_frame),
        .cls              (cls)
    );

    sfcv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (cls),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    sfcv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .computed_sum (computed_sum),
        .received_sum (received_sum)
    );

endmodule
